FILE: hdl/esd_pkg.sv
// Shared types for the escape stream decoder: state codes, result record and
// the push request passed from the decoder to the result queue. No dependencies.
`default_nettype none

package esd_pkg;

  // Decoder state, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_ESC  = 6'b000010,
    MODE_HEX0 = 6'b000100,
    MODE_HEX1 = 6'b001000,
    MODE_OCT1 = 6'b010000,
    MODE_OCT2 = 6'b100000
  } mode_e;

  // One decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       bad_escape;
  } result_t;

  // Results produced by one input request, in order (r0 first)
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

FILE: hdl/esd_decode.sv
// Escape decoder state and per-character decode logic.
// Depends on esd_pkg; feeds zero, one or two results to esd_result_fifo.
`default_nettype none

module esd_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     in_char_i,
  output esd_pkg::push_t      push_o
);

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChBsl  = 8'h5c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLa   = 8'h61;
  localparam logic [7:0] ChLf   = 8'h66;
  localparam logic [7:0] ChUa   = 8'h41;
  localparam logic [7:0] ChUf   = 8'h46;
  localparam logic [7:0] ChLx   = 8'h78;
  localparam logic [7:0] ChUx   = 8'h58;

  esd_pkg::mode_e mode_q, mode_d;
  logic [7:0]     acc_q, acc_d;
  logic           upper_q, upper_d;

  logic           hex_ok;
  logic [3:0]     hex_val;
  logic           oct_ok;
  logic [2:0]     oct_val;

  logic              pre_vld, run_plain, plain_vld;
  esd_pkg::result_t  pre_res, plain_res;

  // Classify the character as hex or octal digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (in_char_i >= ChZero && in_char_i <= ChNine) begin
      hex_val = 4'(in_char_i - ChZero);
    end else if (in_char_i >= ChLa && in_char_i <= ChLf) begin
      hex_val = 4'(in_char_i - ChLa + 8'd10);
    end else if (in_char_i >= ChUa && in_char_i <= ChUf) begin
      hex_val = 4'(in_char_i - ChUa + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    oct_ok  = (in_char_i >= ChZero) && (in_char_i <= ChSeven);
    oct_val = in_char_i[2:0];
  end

  // Close any pending escape, then handle the character plainly if needed
  always_comb begin
    pre_vld   = 1'b0;
    pre_res   = '0;
    run_plain = 1'b0;
    plain_vld = 1'b0;
    plain_res = '0;
    mode_d    = mode_q;
    acc_d     = acc_q;
    upper_d   = upper_q;

    unique case (mode_q)
      esd_pkg::MODE_ESC: begin
        mode_d  = esd_pkg::MODE_IDLE;
        pre_vld = 1'b1;
        case (in_char_i)
          ChNul: begin
            pre_res = '{out_byte: 8'h00, line_end: 1'b1, bad_escape: 1'b1};
            acc_d   = '0;
            upper_d = 1'b0;
          end
          8'h61:   pre_res.out_byte = 8'h07;
          8'h62:   pre_res.out_byte = 8'h08;
          8'h66:   pre_res.out_byte = 8'h0c;
          8'h6e:   pre_res.out_byte = 8'h0a;
          8'h72:   pre_res.out_byte = 8'h0d;
          8'h74:   pre_res.out_byte = 8'h09;
          8'h76:   pre_res.out_byte = 8'h0b;
          ChLx, ChUx: begin
            pre_vld = 1'b0;
            mode_d  = esd_pkg::MODE_HEX0;
            upper_d = (in_char_i == ChUx);
            acc_d   = '0;
          end
          default: begin
            if (oct_ok) begin
              pre_vld = 1'b0;
              mode_d  = esd_pkg::MODE_OCT1;
              acc_d   = {5'b0, oct_val};
            end else begin
              pre_res.out_byte = in_char_i;
            end
          end
        endcase
      end
      esd_pkg::MODE_HEX0: begin
        if (hex_ok) begin
          acc_d  = {4'b0, hex_val};
          mode_d = esd_pkg::MODE_HEX1;
        end else begin
          pre_vld          = 1'b1;
          pre_res.out_byte = upper_q ? ChUx : ChLx;
          run_plain        = 1'b1;
        end
      end
      esd_pkg::MODE_HEX1: begin
        pre_vld = 1'b1;
        mode_d  = esd_pkg::MODE_IDLE;
        if (hex_ok) begin
          pre_res.out_byte = {acc_q[3:0], hex_val};
          acc_d            = '0;
        end else begin
          pre_res.out_byte = acc_q;
          run_plain        = 1'b1;
        end
      end
      esd_pkg::MODE_OCT1: begin
        if (oct_ok) begin
          if (acc_q <= 8'd3) begin
            acc_d  = {acc_q[4:0], oct_val};
            mode_d = esd_pkg::MODE_OCT2;
          end else begin
            pre_vld          = 1'b1;
            pre_res.out_byte = {acc_q[4:0], oct_val};
            acc_d            = '0;
            mode_d           = esd_pkg::MODE_IDLE;
          end
        end else begin
          pre_vld          = 1'b1;
          pre_res.out_byte = acc_q;
          mode_d           = esd_pkg::MODE_IDLE;
          run_plain        = 1'b1;
        end
      end
      esd_pkg::MODE_OCT2: begin
        pre_vld = 1'b1;
        mode_d  = esd_pkg::MODE_IDLE;
        if (oct_ok) begin
          pre_res.out_byte = {acc_q[4:0], oct_val};
          acc_d            = '0;
        end else begin
          pre_res.out_byte = acc_q;
          run_plain        = 1'b1;
        end
      end
      default: run_plain = 1'b1;
    endcase

    // Plain character: end of line, new escape or literal
    if (run_plain) begin
      if (in_char_i == ChNul) begin
        plain_vld = 1'b1;
        plain_res = '{out_byte: 8'h00, line_end: 1'b1, bad_escape: 1'b0};
        mode_d    = esd_pkg::MODE_IDLE;
        acc_d     = '0;
        upper_d   = 1'b0;
      end else if (in_char_i == ChBsl) begin
        mode_d = esd_pkg::MODE_ESC;
      end else begin
        plain_vld          = 1'b1;
        plain_res.out_byte = in_char_i;
        mode_d             = esd_pkg::MODE_IDLE;
      end
    end
  end

  // Pack the results of this request in order
  always_comb begin
    push_o.num = accept_i ? ({1'b0, pre_vld} + {1'b0, plain_vld}) : 2'd0;
    push_o.r0  = pre_vld ? pre_res : plain_res;
    push_o.r1  = plain_res;
  end

  // Advance decoder state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= esd_pkg::MODE_IDLE;
      acc_q   <= '0;
      upper_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      upper_q <= upper_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/esd_result_fifo.sv
// Three-entry result queue taking up to two results per cycle, giving one.
// Depends on esd_pkg; written by esd_decode.
`default_nettype none

module esd_result_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire esd_pkg::push_t    push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output esd_pkg::result_t       out_res_o
);

  localparam int unsigned Depth = 3;

  esd_pkg::result_t mem_q [Depth];
  logic [1:0] rd_q, rd_d;
  logic [1:0] wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] wr_nxt;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = mem_q[rd_q];
  // Room for two results, so a request is never refused mid-way
  assign room_o      = (cnt_q <= 2'd1);
  assign wr_nxt      = ptr_inc(wr_q);

  // Pointer and fill count update
  always_comb begin
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    wr_d  = (push_i.num == 2'd2) ? ptr_inc(wr_nxt) :
            (push_i.num == 2'd1) ? wr_nxt : wr_q;
    cnt_d = cnt_q + push_i.num - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Write storage: first result at the write pointer, second after it
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/c_escape_stream_decoder.sv
// Top level of the C escape stream decoder: decoder plus result queue.
// Depends on esd_pkg, esd_decode and esd_result_fifo.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, in_char_i         | in
//   output  | out_valid_o, out_ready_i, out_byte_o,     | out
//           | line_end_o, bad_escape_o                  |
//
// One character is taken per cycle while in_ready_o is high; its results enter
// the queue at the same edge and the first can be taken in the next cycle.
// in_ready_o is high while the three-entry queue holds at most one result, so
// a character giving two results stalls the next one even when the output
// drains at one per cycle. Reset returns the decoder to idle and empties the
// queue. A stalled output fills the queue and then holds input off.
`default_nettype none

module c_escape_stream_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            line_end_o,
  output logic            bad_escape_o
);

  esd_pkg::push_t   push;
  esd_pkg::result_t out_res;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  esd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (in_char_i),
    .push_o    (push)
  );

  esd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign line_end_o   = out_res.line_end;
  assign bad_escape_o = out_res.bad_escape;

endmodule

`default_nettype wire

FILE: hdl/esd_checker.sv
// Port-level checks for c_escape_stream_decoder, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module esd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       line_end_o,
  input wire logic       bad_escape_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(line_end_o) && $stable(bad_escape_o))
    else $error("stalled result changed");

  // Error result always closes the line
  a_bad_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_escape_o |-> line_end_o)
    else $error("bad escape without line end");

  // Line end carries a zero byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> out_byte_o == 8'h00)
    else $error("line end with non-zero byte");

  // Empty output side never holds off input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty queue");

  // A request accepted while the output is stalled leaves a result waiting
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("queued result lost");

endmodule

bind c_escape_stream_decoder esd_checker u_esd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .line_end_o   (line_end_o),
  .bad_escape_o (bad_escape_o)
);

`default_nettype wire

FILE: tb/sv/c_escape_stream_decoder_tb.sv
// Testbench for c_escape_stream_decoder: random idling on both channels plus
// a bit-exact decoder prediction in the testbench. Depends on esd_pkg and the RTL.
`default_nettype none

module c_escape_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_LEN   = 11;
  localparam int unsigned RANDOM_LEN  = 600;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_LEN   = 20;
  localparam int unsigned MAX_CYCLES  = 400_000;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LO   = "x";
  localparam logic [7:0] CH_X_UP   = "X";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [4:0] NOT_HEX   = 5'd16;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       line_end;
  logic       bad_escape;

  // Characters waiting to be offered, and decoded results still to arrive
  logic [7:0]        line_chars[$];
  esd_pkg::result_t  decoded_q[$];

  // Decoder state as predicted by the testbench
  esd_pkg::mode_e    esc_mode = esd_pkg::MODE_IDLE;
  logic [7:0]        esc_accum = '0;
  logic              esc_upper = 1'b0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned chars_taken = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          held_once = 1'b0;

  c_escape_stream_decoder DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_char_i    (in_char),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .line_end_o   (line_end),
    .bad_escape_o (bad_escape)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle cycles before the next request or result; every third stretch of 64 has none
  function automatic int unsigned idle_cycles(int unsigned n);
    return ((n / 64) % 3 == 1) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return NOT_HEX;
  endfunction

  function automatic bit is_octal(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  task automatic emit(logic [7:0] b, logic closes, logic bad);
    esd_pkg::result_t r;
    r.out_byte   = b;
    r.line_end   = closes;
    r.bad_escape = bad;
    decoded_q.push_back(r);
  endtask

  task automatic clear_escape();
    esc_mode  = esd_pkg::MODE_IDLE;
    esc_accum = '0;
    esc_upper = 1'b0;
  endtask

  // Character with no escape pending
  task automatic decode_plain(logic [7:0] c);
    if (c == CH_NUL) begin
      clear_escape();
      emit(8'h00, 1'b1, 1'b0);
    end else if (c == CH_BSLASH) begin
      esc_mode = esd_pkg::MODE_ESC;
    end else begin
      esc_mode = esd_pkg::MODE_IDLE;
      emit(c, 1'b0, 1'b0);
    end
  endtask

  // Character straight after a backslash
  task automatic decode_escaped(logic [7:0] c);
    logic [7:0] b;
    b = c;
    case (c)
      CH_NUL: begin
        clear_escape();
        emit(8'h00, 1'b1, 1'b1);
        return;
      end
      "a": b = 8'h07;
      "b": b = 8'h08;
      "f": b = 8'h0C;
      "n": b = 8'h0A;
      "r": b = 8'h0D;
      "t": b = 8'h09;
      "v": b = 8'h0B;
      CH_X_LO, CH_X_UP: begin
        esc_mode  = esd_pkg::MODE_HEX0;
        esc_upper = (c == CH_X_UP);
        esc_accum = '0;
        return;
      end
      default: begin
        if (is_octal(c)) begin
          esc_mode  = esd_pkg::MODE_OCT1;
          esc_accum = c - CH_ZERO;
          return;
        end
      end
    endcase
    esc_mode = esd_pkg::MODE_IDLE;
    emit(b, 1'b0, 1'b0);
  endtask

  // Advance the predicted decoder by one accepted request
  task automatic decode_char(logic [7:0] c);
    logic [4:0] hv;
    logic [7:0] acc;
    logic [7:0] v;
    hv  = hex_digit(c);
    acc = esc_accum;
    v   = {acc[4:0], c[2:0]};
    case (esc_mode)
      esd_pkg::MODE_ESC: decode_escaped(c);
      esd_pkg::MODE_HEX0: begin
        if (hv != NOT_HEX) begin
          esc_accum = {4'h0, hv[3:0]};
          esc_mode  = esd_pkg::MODE_HEX1;
        end else begin
          emit(esc_upper ? CH_X_UP : CH_X_LO, 1'b0, 1'b0);
          esc_mode = esd_pkg::MODE_IDLE;
          decode_plain(c);
        end
      end
      esd_pkg::MODE_HEX1: begin
        esc_mode = esd_pkg::MODE_IDLE;
        if (hv != NOT_HEX) begin
          esc_accum = '0;
          emit({acc[3:0], hv[3:0]}, 1'b0, 1'b0);
        end else begin
          emit(acc, 1'b0, 1'b0);
          decode_plain(c);
        end
      end
      esd_pkg::MODE_OCT1: begin
        if (is_octal(c)) begin
          if (acc <= 8'd3) begin
            esc_accum = v;
            esc_mode  = esd_pkg::MODE_OCT2;
          end else begin
            esc_mode  = esd_pkg::MODE_IDLE;
            esc_accum = '0;
            emit(v, 1'b0, 1'b0);
          end
        end else begin
          esc_mode = esd_pkg::MODE_IDLE;
          emit(acc, 1'b0, 1'b0);
          decode_plain(c);
        end
      end
      esd_pkg::MODE_OCT2: begin
        esc_mode = esd_pkg::MODE_IDLE;
        if (is_octal(c)) begin
          esc_accum = '0;
          emit(v, 1'b0, 1'b0);
        end else begin
          emit(acc, 1'b0, 1'b0);
          decode_plain(c);
        end
      end
      default: begin
        esc_mode = esd_pkg::MODE_IDLE;
        decode_plain(c);
      end
    endcase
  endtask

  // Append one random piece of a line: mostly well-formed escapes, some noise
  task automatic add_piece();
    string       letters;
    string       hexes;
    int unsigned kind;
    int unsigned ndig;
    logic [7:0]  c;
    letters = "abfnrtv\\";
    hexes   = "0123456789abcdefABCDEF";
    kind    = $urandom_range(0, 99);
    if (kind < 25) begin
      c = 8'($urandom_range(1, 255));
      line_chars.push_back(c == CH_BSLASH ? 8'h5D : c);
    end else if (kind < 40) begin
      line_chars.push_back(CH_BSLASH);
      line_chars.push_back(letters[$urandom_range(0, letters.len() - 1)]);
    end else if (kind < 60) begin
      line_chars.push_back(CH_BSLASH);
      line_chars.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
      ndig = $urandom_range(0, 2);
      repeat (ndig) line_chars.push_back(hexes[$urandom_range(0, hexes.len() - 1)]);
    end else if (kind < 80) begin
      line_chars.push_back(CH_BSLASH);
      ndig = $urandom_range(1, 3);
      repeat (ndig) line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
    end else if (kind < 90) begin
      line_chars.push_back(CH_BSLASH);
      line_chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      line_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Input side: offer the next character once the drawn gap has elapsed
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_char(in_char);
        chars_taken++;
        gap_left = idle_cycles(chars_taken);
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (line_chars.size() != 0) begin
        in_valid <= 1'b1;
        in_char  <= line_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: check each result against the oldest prediction, then stall
  always @(posedge clk) begin
    esd_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          $error("result with none predicted: out_byte %0h line_end %0b bad_escape %0b",
                 out_byte, line_end, bad_escape);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
            fail_count++;
          end
          if (line_end !== want.line_end) begin
            $error("line_end: expected %0b, got %0b", want.line_end, line_end);
            fail_count++;
          end
          if (bad_escape !== want.bad_escape) begin
            $error("bad_escape: expected %0b, got %0b", want.bad_escape, bad_escape);
            fail_count++;
          end
        end
        // Hold off once for a long stretch so the queue fills and input stalls
        if (!held_once && results_seen == HOLD_AT) begin
          held_once  = 1'b1;
          stall_left = HOLD_CYCLES;
        end else begin
          stall_left = idle_cycles(results_seen);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned start;
    int unsigned total;
    // Directed: byte extremes, a hex escape and octal limits, flush at end of line,
    // letter after x, digit 9 escaped and a backslash right before end of line
    line_chars = '{8'hFF,
                   CH_BSLASH, "n",
                   CH_BSLASH, CH_X_LO, "4", "1",
                   CH_BSLASH, CH_X_UP, "g",
                   CH_BSLASH, "3", "7", "7",
                   CH_BSLASH, "7", "7", "7",
                   CH_BSLASH, "9",
                   CH_BSLASH, CH_X_LO, "f", CH_NUL,
                   CH_BSLASH, CH_NUL};

    // Random lines, each closed by a zero, sometimes straight after a backslash
    start = line_chars.size();
    while (line_chars.size() - start < RANDOM_LEN) begin
      repeat ($urandom_range(1, 12)) add_piece();
      if ($urandom_range(0, 19) == 0) line_chars.push_back(CH_BSLASH);
      line_chars.push_back(CH_NUL);
    end
    total = line_chars.size();

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every result to arrive
    while (chars_taken < total) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/esd_pkg.sv
hdl/esd_decode.sv
hdl/esd_result_fifo.sv
hdl/c_escape_stream_decoder.sv
hdl/esd_checker.sv
tb/sv/c_escape_stream_decoder_tb.sv
